### rtl/ssp_pkg.sv
// Shared types, constants and tables for the Stanley steering and PID speed unit.
package ssp_pkg;

   // Field and datapath widths
   localparam int OFFSET_WIDTH = 12;
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_LEN     = 24;
   localparam int ATAN_IDX_W   = $clog2(ATAN_LEN);
   localparam int CORD_CNT_W   = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

   localparam int MUL_A_W   = 34;
   localparam int MUL_B_W   = 20;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);
   localparam int DIV_N_W   = PROD_W;
   localparam int DIV_D_W   = 20;
   localparam int DIV_CNT_W = $clog2(DIV_N_W);
   localparam int CORD_W    = 42;
   localparam int ANG_W     = 20;
   localparam int SUM_W     = 56;

   localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = ANG_W'(102944);

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_SPEED = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CROSS_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN   = 3'd4;

   typedef struct packed {
      logic [15:0]             left_angle;
      logic [15:0]             right_angle;
      logic [OFFSET_WIDTH-1:0] left_offset;
      logic [OFFSET_WIDTH-1:0] right_offset;
      logic [15:0]             speed_meas;
      logic [19:0]             time_step_us;
   } req_payload_type;

   typedef struct packed {
      logic [15:0]        accel_cmd;
      logic signed [15:0] steering_cmd;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HEAD,
      ST_CTE,
      ST_YMUL,
      ST_CORD,
      ST_STEER,
      ST_PMUL,
      ST_IMUL1,
      ST_IDIV,
      ST_IMUL2,
      ST_DMUL1,
      ST_DMUL2,
      ST_DDIV,
      ST_OUT
   } state_type;

   // Arctangent of 2^-i in radians, Q16.
   function automatic logic [16:0] atan_lookup(input logic [ATAN_IDX_W-1:0] idx);
      logic [16:0] val;
      case (idx)
         5'd0:    val = 17'd51472;
         5'd1:    val = 17'd30386;
         5'd2:    val = 17'd16055;
         5'd3:    val = 17'd8150;
         5'd4:    val = 17'd4091;
         5'd5:    val = 17'd2047;
         5'd6:    val = 17'd1024;
         5'd7:    val = 17'd512;
         5'd8:    val = 17'd256;
         5'd9:    val = 17'd128;
         5'd10:   val = 17'd64;
         5'd11:   val = 17'd32;
         5'd12:   val = 17'd16;
         5'd13:   val = 17'd8;
         5'd14:   val = 17'd4;
         5'd15:   val = 17'd2;
         5'd16:   val = 17'd1;
         default: val = 17'd0;
      endcase
      return val;
   endfunction

endpackage

### rtl/stanley_steering_pid_speed_unit.sv
// Stanley steering and PID throttle controller, top level with sequencer.
// Throughput: one item at a time through the shared bit-serial units; the next item is
// taken in the cycle after the result is loaded, even while that result still waits.
// Reset is synchronous and active high: registers return to their reset values and the
// controller forgets its integral, last error and first-step flag.
module stanley_steering_pid_speed_unit import ssp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_payload_type      req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_payload_type      rsp_data,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data
);

   state_type state_ff, state_in;
   logic      go_ff, go_in;
   logic      req_accept;
   logic      out_load;

   // Configuration and controller state
   logic [15:0]        tgt_ff, cg_ff, pg_ff, ig_ff, dg_ff;
   logic               first_done_ff;
   logic signed [31:0] integral_ff;
   logic signed [16:0] last_err_ff;
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_data_ff;

   // Per-item working registers
   req_payload_type          req_ff;
   logic signed [ANG_W-1:0]  heading_ff;
   logic signed [17:0]       cte_ff;
   logic signed [15:0]       steer_ff;
   logic signed [SUM_W-1:0]  p_ff, i_ff, d_ff;

   // Shared arithmetic units
   logic               mul_start, mul_done, mul_use;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0]  prod;
   logic               div_start, div_done, div_use;
   logic [DIV_N_W-1:0] div_num;
   logic [DIV_D_W-1:0] div_den;
   logic [DIV_N_W-1:0] quot;
   logic               cord_start, cord_done;
   logic signed [CORD_W-1:0] cord_y, cord_x;
   logic signed [ANG_W-1:0]  ang;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign out_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   // Heading error: mean angle less 90 degrees, wrapped, in units of 0.005 degree.
   logic [16:0]        angle_sum;
   logic signed [18:0] e_raw;
   logic signed [17:0] e_wrap;
   logic [17:0]        e_abs;
   logic [PROD_W-1:0]  head_rnd;
   logic [ANG_W-1:0]   head_mag;

   assign angle_sum = {1'b0, req_ff.left_angle} + {1'b0, req_ff.right_angle};
   assign e_raw     = signed'({2'b0, angle_sum}) - 19'sd18000;
   // Out-of-range angles can put the sum almost two turns high, so wrap once or twice.
   assign e_wrap    = (e_raw > 19'sd108000) ? 18'(e_raw - 19'sd144000)
                    : (e_raw > 19'sd36000)  ? 18'(e_raw - 19'sd72000) : 18'(e_raw);
   assign e_abs     = e_wrap[17] ? 18'(-e_wrap) : 18'(e_wrap);
   assign head_rnd  = prod + PROD_W'(32768);
   assign head_mag  = ANG_W'(head_rnd[PROD_W-1:16]);

   // Cross-track error as a rounded offset ratio.
   logic [OFFSET_WIDTH:0]   off_sum;
   logic                    off_neg;
   logic [OFFSET_WIDTH-1:0] off_dmag;
   logic                    sum_zero;
   logic [DIV_N_W-1:0]      cte_num;
   logic [17:0]             cte_abs;

   assign off_sum  = {1'b0, req_ff.left_offset} + {1'b0, req_ff.right_offset};
   assign off_neg  = (req_ff.left_offset < req_ff.right_offset);
   assign off_dmag = off_neg ? (req_ff.right_offset - req_ff.left_offset)
                             : (req_ff.left_offset - req_ff.right_offset);
   assign sum_zero = (off_sum == '0);
   assign cte_num  = DIV_N_W'({off_dmag, 16'b0}) + DIV_N_W'(off_sum >> 1);
   assign cte_abs  = cte_ff[17] ? 18'(-cte_ff) : 18'(cte_ff);

   // CORDIC operands: y = gain * cte * 36, x = target * 655360.
   logic [CORD_W-1:0] y_mag;

   assign y_mag  = (CORD_W'(prod) << 5) + (CORD_W'(prod) << 2);
   assign cord_y = cte_ff[17] ? -signed'(y_mag) : signed'(y_mag);
   assign cord_x = signed'((CORD_W'(tgt_ff) << 19) + (CORD_W'(tgt_ff) << 17));

   // Steering: scale the summed angle and saturate.
   logic signed [ANG_W-1:0] steer_sum;
   logic [ANG_W-1:0]        steer_abs;
   logic [PROD_W-1:0]       steer_rnd;
   logic [PROD_W-21:0]      steer_mag;
   logic signed [15:0]      steer_val;

   assign steer_sum = heading_ff + ang;
   assign steer_abs = steer_sum[ANG_W-1] ? ANG_W'(-steer_sum) : ANG_W'(steer_sum);
   assign steer_rnd = prod + PROD_W'(1 << 19);
   assign steer_mag = steer_rnd[PROD_W-1:20];

   always_comb begin
      if (!steer_sum[ANG_W-1]) begin
         steer_val = (steer_mag > (PROD_W-20)'(32767)) ? 16'sh7FFF
                                                      : signed'(steer_mag[15:0]);
      end else begin
         steer_val = (steer_mag > (PROD_W-20)'(32768)) ? 16'sh8000
                                                      : signed'(16'(16'd0 - steer_mag[15:0]));
      end
   end

   // Speed error, integral update and PID terms.
   logic signed [16:0] err;
   logic [16:0]        err_abs;
   logic signed [17:0] diff;
   logic [17:0]        diff_abs;
   logic [31:0]        integ_abs;
   logic [DIV_N_W-1:0] inc_num;
   logic signed [33:0] inc_s, integ_sum, lim;
   logic signed [31:0] integ_clamped;
   logic [PROD_W-1:0]  i_rnd;
   logic [SUM_W-1:0]   i_mag;
   logic [DIV_N_W-1:0] d_num;
   logic signed [SUM_W-1:0] outq;
   logic [15:0]        accel_val;

   assign err       = signed'({1'b0, tgt_ff}) - signed'({1'b0, req_ff.speed_meas});
   assign err_abs   = err[16] ? 17'(-err) : 17'(err);
   assign diff      = 18'(err) - 18'(last_err_ff);
   assign diff_abs  = diff[17] ? 18'(-diff) : 18'(diff);
   assign integ_abs = integral_ff[31] ? 32'(-integral_ff) : 32'(integral_ff);
   assign inc_num   = (prod << 2) + DIV_N_W'(7812);
   assign inc_s     = err[16] ? -signed'(34'(quot)) : signed'(34'(quot));
   assign integ_sum = 34'(integral_ff) + inc_s;
   assign lim       = signed'((34'(tgt_ff) << 11) + (34'(tgt_ff) << 9));

   always_comb begin
      if (integ_sum > lim) begin
         integ_clamped = 32'(lim);
      end else if (integ_sum < -lim) begin
         integ_clamped = 32'(-lim);
      end else begin
         integ_clamped = 32'(integ_sum);
      end
   end

   assign i_rnd = prod + PROD_W'(128);
   assign i_mag = SUM_W'(i_rnd >> 8);
   assign d_num = prod + DIV_N_W'(req_ff.time_step_us >> 1);
   assign outq  = p_ff + i_ff + d_ff;

   always_comb begin
      if (outq < 0) begin
         accel_val = 16'd0;
      end else if (outq > SUM_W'(65535)) begin
         accel_val = 16'hFFFF;
      end else begin
         accel_val = outq[15:0];
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_accept) state_in = ST_HEAD;
         ST_HEAD:  if (mul_done) state_in = ST_CTE;
         ST_CTE:   if (sum_zero || div_done) state_in = ST_YMUL;
         ST_YMUL:  if (mul_done) state_in = ST_CORD;
         ST_CORD:  if (cord_done) state_in = ST_STEER;
         ST_STEER: if (mul_done) state_in = ST_PMUL;
         ST_PMUL:  if (mul_done) state_in = first_done_ff ? ST_IMUL1 : ST_OUT;
         ST_IMUL1: if (mul_done) state_in = ST_IDIV;
         ST_IDIV:  if (div_done) state_in = ST_IMUL2;
         ST_IMUL2: begin
            if (mul_done) begin
               state_in = (req_ff.time_step_us == '0) ? ST_OUT : ST_DMUL1;
            end
         end
         ST_DMUL1: if (mul_done) state_in = ST_DMUL2;
         ST_DMUL2: if (mul_done) state_in = ST_DDIV;
         ST_DDIV:  if (div_done) state_in = ST_OUT;
         ST_OUT:   if (out_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign go_in = (state_in != state_ff);

   // Unit operands and start strobes for each state
   always_comb begin
      mul_use = 1'b0;
      mul_a   = '0;
      mul_b   = '0;
      div_use = 1'b0;
      div_num = '0;
      div_den = '0;
      case (state_ff)
         ST_HEAD: begin
            mul_use = 1'b1;
            mul_a   = MUL_A_W'(e_abs);
            mul_b   = MUL_B_W'(374807);
         end
         ST_CTE: begin
            div_use = !sum_zero;
            div_num = cte_num;
            div_den = DIV_D_W'(off_sum);
         end
         ST_YMUL: begin
            mul_use = 1'b1;
            mul_a   = MUL_A_W'(cte_abs);
            mul_b   = MUL_B_W'(cg_ff);
         end
         ST_STEER: begin
            mul_use = 1'b1;
            mul_a   = MUL_A_W'(steer_abs);
            mul_b   = MUL_B_W'(65711);
         end
         ST_PMUL: begin
            mul_use = 1'b1;
            mul_a   = MUL_A_W'(err_abs);
            mul_b   = MUL_B_W'(pg_ff);
         end
         ST_IMUL1: begin
            mul_use = 1'b1;
            mul_a   = MUL_A_W'(err_abs);
            mul_b   = MUL_B_W'(req_ff.time_step_us);
         end
         ST_IDIV: begin
            div_use = 1'b1;
            div_num = inc_num;
            div_den = DIV_D_W'(15625);
         end
         ST_IMUL2: begin
            mul_use = 1'b1;
            mul_a   = MUL_A_W'(integ_abs);
            mul_b   = MUL_B_W'(ig_ff);
         end
         ST_DMUL1: begin
            mul_use = 1'b1;
            mul_a   = MUL_A_W'(diff_abs);
            mul_b   = MUL_B_W'(dg_ff);
         end
         ST_DMUL2: begin
            mul_use = 1'b1;
            mul_a   = prod[MUL_A_W-1:0];
            mul_b   = MUL_B_W'(1000000);
         end
         ST_DDIV: begin
            div_use = 1'b1;
            div_num = d_num;
            div_den = DIV_D_W'(req_ff.time_step_us);
         end
         default: begin
            mul_use = 1'b0;
         end
      endcase
   end

   assign mul_start  = go_ff && mul_use;
   assign div_start  = go_ff && div_use;
   assign cord_start = go_ff && (state_ff == ST_CORD);

   ssp_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a_mag (mul_a),
      .b_mag (mul_b),
      .done  (mul_done),
      .prod  (prod)
   );

   ssp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (quot)
   );

   ssp_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cord_start),
      .y_in  (cord_y),
      .x_in  (cord_x),
      .done  (cord_done),
      .ang   (ang)
   );

   // Control state, configuration and controller memory
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         go_ff         <= 1'b0;
         tgt_ff        <= 16'd0;
         cg_ff         <= 16'd256;
         pg_ff         <= 16'd0;
         ig_ff         <= 16'd0;
         dg_ff         <= 16'd0;
         first_done_ff <= 1'b0;
         integral_ff   <= '0;
         last_err_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= go_in;
         if (csr_write) begin
            case (csr_index)
               CSR_TARGET_SPEED: tgt_ff <= csr_data;
               CSR_CROSS_GAIN:   cg_ff  <= csr_data;
               CSR_PROP_GAIN:    pg_ff  <= csr_data;
               CSR_INTEG_GAIN:   ig_ff  <= csr_data;
               CSR_DERIV_GAIN:   dg_ff  <= csr_data;
               default:          tgt_ff <= tgt_ff;
            endcase
         end
         if ((state_ff == ST_IDIV) && div_done) begin
            integral_ff <= integ_clamped;
         end
         if (out_load) begin
            first_done_ff <= 1'b1;
            last_err_ff   <= err;
            if (!first_done_ff) begin
               integral_ff <= '0;
            end
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Per-item datapath registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_data;
         i_ff   <= '0;
         d_ff   <= '0;
      end
      if ((state_ff == ST_HEAD) && mul_done) begin
         heading_ff <= e_wrap[17] ? -signed'(head_mag) : signed'(head_mag);
      end
      if (state_ff == ST_CTE) begin
         if (sum_zero) begin
            cte_ff <= '0;
         end else if (div_done) begin
            cte_ff <= off_neg ? -signed'(18'(quot)) : signed'(18'(quot));
         end
      end
      if ((state_ff == ST_STEER) && mul_done) begin
         steer_ff <= steer_val;
      end
      if ((state_ff == ST_PMUL) && mul_done) begin
         p_ff <= err[16] ? -signed'(SUM_W'(prod)) : signed'(SUM_W'(prod));
      end
      if ((state_ff == ST_IMUL2) && mul_done) begin
         i_ff <= integral_ff[31] ? -signed'(i_mag) : signed'(i_mag);
      end
      if ((state_ff == ST_DDIV) && div_done) begin
         d_ff <= diff[17] ? -signed'(SUM_W'(quot)) : signed'(SUM_W'(quot));
      end
      if (out_load) begin
         rsp_data_ff.accel_cmd    <= accel_val;
         rsp_data_ff.steering_cmd <= steer_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // The multiplier only finishes in a state that issued a multiply.
   assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_HEAD || state_ff == ST_YMUL || state_ff == ST_STEER ||
                    state_ff == ST_PMUL || state_ff == ST_IMUL1 || state_ff == ST_IMUL2 ||
                    state_ff == ST_DMUL1 || state_ff == ST_DMUL2))
      else $error("multiplier finished outside a multiply state");

   // The divider only finishes in a state that issued a divide.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_CTE || state_ff == ST_IDIV || state_ff == ST_DDIV))
      else $error("divider finished outside a divide state");

   // The CORDIC result is consumed only in its own state.
   assert property (@(posedge clock) disable iff (reset)
      cord_done |-> (state_ff == ST_CORD))
      else $error("CORDIC finished outside its state");

   // After an integral update the sum lies within the anti-windup limit.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IMUL2) |-> (integral_ff <= lim && integral_ff >= -lim))
      else $error("integral outside anti-windup limit");
`endif

endmodule

### rtl/ssp_mul.sv
// Bit-serial shift-and-add multiplier for unsigned magnitudes.
module ssp_mul import ssp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MUL_A_W-1:0] a_mag,
   input  logic [MUL_B_W-1:0] b_mag,
   output logic               done,
   output logic [PROD_W-1:0]  prod
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W-1:0]    acc_ff, acc_in;
   logic [PROD_W-1:0]    aa_ff, aa_in;
   logic [MUL_B_W-1:0]   bb_ff, bb_in;

   // One multiplier bit per cycle, least significant first.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      aa_in   = aa_ff;
      bb_in   = bb_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         aa_in   = PROD_W'(a_mag);
         bb_in   = b_mag;
      end else if (busy_ff) begin
         if (bb_ff[0]) begin
            acc_in = acc_ff + aa_ff;
         end
         aa_in  = aa_ff << 1;
         bb_in  = bb_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      aa_ff  <= aa_in;
      bb_ff  <= bb_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

### rtl/ssp_div.sv
// Bit-serial restoring divider for unsigned magnitudes.
module ssp_div import ssp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_N_W-1:0] num,
   input  logic [DIV_D_W-1:0] den,
   output logic               done,
   output logic [DIV_N_W-1:0] quot
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_N_W-1:0]   q_ff, q_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_D_W-1:0]   den_ff, den_in;
   logic [DIV_D_W:0]     trial;
   logic [DIV_D_W:0]     trial_sub;
   logic                 fits;

   // Bring down one dividend bit and try the subtraction.
   assign trial     = {rem_ff, q_ff[DIV_N_W-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign fits      = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         q_in   = {q_ff[DIV_N_W-2:0], fits};
         rem_in = fits ? trial_sub[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

### rtl/ssp_cordic.sv
// Iterative vectoring CORDIC that returns atan2(y, x) for x >= 0 in Q16 radians.
module ssp_cordic import ssp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [CORD_W-1:0] y_in,
   input  logic signed [CORD_W-1:0] x_in,
   output logic                     done,
   output logic signed [ANG_W-1:0]  ang
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CORD_CNT_W-1:0]   cnt_ff, cnt_in;
   logic signed [CORD_W-1:0] x_ff, x_in_n;
   logic signed [CORD_W-1:0] y_ff, y_in_n;
   logic signed [ANG_W-1:0]  z_ff, z_in;
   logic signed [CORD_W-1:0] dx, dy;
   logic signed [ANG_W-1:0]  step_ang;

   // Shifted operands and table angle of the current iteration.
   assign dx       = y_ff >>> cnt_ff;
   assign dy       = x_ff >>> cnt_ff;
   assign step_ang = signed'(ANG_W'(atan_lookup(ATAN_IDX_W'(cnt_ff))));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in_n  = x_ff;
      y_in_n  = y_ff;
      z_in    = z_ff;
      if (start) begin
         cnt_in = '0;
         x_in_n = x_in;
         y_in_n = y_in;
         z_in   = '0;
         if (y_in == '0) begin
            done_in = 1'b1;
         end else if (x_in == '0) begin
            z_in    = y_in[CORD_W-1] ? -HALF_PI_Q16 : HALF_PI_Q16;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         // Rotate toward the x axis by the sign of y.
         if (!y_ff[CORD_W-1]) begin
            x_in_n = x_ff + dx;
            y_in_n = y_ff - dy;
            z_in   = z_ff + step_ang;
         end else begin
            x_in_n = x_ff - dx;
            y_in_n = y_ff + dy;
            z_in   = z_ff - step_ang;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CORD_CNT_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      x_ff   <= x_in_n;
      y_ff   <= y_in_n;
      z_ff   <= z_in;
   end

   assign done = done_ff;
   assign ang  = z_ff;

endmodule
